@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset.
`define AST_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while in reset.
`define AST_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define AST_IMP(lbl, ck, rn, ante, cons)
`define AST_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

@@ rtl/yrv_pkg.sv @@
// Types and constants of the YUV/RGB to display pixel converter.
// Used by yrv_cfg, yrv_csc, yrv_pack and the top level; depends on nothing.
`default_nettype none

package yrv_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int WORD_W      = 32;
    localparam int NUM_CHAN    = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_FORMAT     = 3'd0,
        REG_VISUAL_PRESENT = 3'd1,
        REG_RED_MASK       = 3'd2,
        REG_GREEN_MASK     = 3'd3,
        REG_BLUE_MASK      = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_YUV   = 2'd0,
        FMT_RGB24 = 2'd1,
        FMT_BGR24 = 2'd2
    } pix_fmt_t;

    localparam logic [WORD_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

    // Placement of one channel, derived from its mask when the mask is written.
    // Scale to n bits: c*qn + floor((c*rm1 + 127)/255), qn = (2^n - 2^(n%8))/255,
    // rm1 = 2^(n%8) - 1.
    typedef struct packed {
        logic [WORD_W-1:0] mask;
        logic [4:0]        pos;
        logic [24:0]       qn;
        logic [6:0]        rm1;
    } chan_place_t;

    typedef struct packed {
        logic [1:0]                       src_format;
        logic                             visual_present;
        chan_place_t [NUM_CHAN-1:0]       place;
    } cfg_t;

    // Channel bytes after colour conversion; bad marks an unused format code.
    typedef struct packed {
        logic       bad;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

endpackage

`default_nettype wire

@@ rtl/yuv_rgb_to_visual_pixel.sv @@
// Pixel converter: three bytes in, one packed display word out, per item.
// An item passes through five register stages (input, product, clamp,
// scale-product, output) on its way to m_tvalid. Throughput: one item per
// cycle; a held result stalls only the full stages behind it, bubbles close up.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads
// format YUV, no visual and masks 0x00FF0000 / 0x0000FF00 / 0x000000FF.
`default_nettype none

`include "assert_macros.svh"

module yuv_rgb_to_visual_pixel
    import yrv_pkg::*;
#(
    parameter int PIXEL_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,    // byte_a [7:0], byte_b [15:8], byte_c [23:16]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WORD_W-1:0]      m_tdata,    // pixel_word [31:0]
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    logic csc_valid;
    logic csc_ready;
    rgb_t csc_pix;

    // Registers, with each mask decoded into position and scale terms on write.
    yrv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages 1-3: register the bytes, form the BT.601 products, then floor,
    // add luma, clamp and pick the channel order for the format in force.
    yrv_csc u_csc (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_format   (cfg.src_format),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_a         (s_tdata[7:0]),
        .in_b         (s_tdata[15:8]),
        .in_c         (s_tdata[23:16]),
        .out_valid    (csc_valid),
        .out_ready    (csc_ready),
        .out_pix      (csc_pix)
    );

    // Stages 4-5: scale each channel to its mask run with rounding, shift it
    // into place, AND with the mask and merge; or pack 0x00RRGGBB. Stage 5 is
    // the output register; while it holds a result, only full stages behind stall.
    yrv_pack #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (csc_valid),
        .in_ready  (csc_ready),
        .in_pix    (csc_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

    // An empty output register means every stage can take an item.
    `AST_IMP(a_ready_when_drained, clk, rst_n, !m_tvalid, s_tready)
    // The packer only pushes back while its output is held.
    `AST_IMP(a_pack_stall_cause, clk, rst_n, !csc_ready, m_tvalid && !m_tready)
    // Hold a converted item between the halves until the packer takes it.
    `AST_NXT(a_csc_hold, clk, rst_n, csc_valid && !csc_ready, csc_valid && $stable(csc_pix))

endmodule

`default_nettype wire

@@ rtl/yrv_cfg.sv @@
// Configuration registers of the converter and per-channel mask decode.
// Depends on yrv_pkg.
`default_nettype none

module yrv_cfg
    import yrv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    // Find the lowest run of ones: its position, its width n, and the scale terms.
    function automatic chan_place_t calc_place(input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] low;
        logic [WORD_W:0]   s;
        logic [WORD_W:0]   endb;
        logic [5:0]        p;
        logic [5:0]        e;
        logic [5:0]        n;
        logic [24:0]       rep;
        chan_place_t       res;
        low  = m & (~m + 32'd1);
        s    = {1'b0, m} + {1'b0, low};
        endb = s & ~{1'b0, m};
        p    = '0;
        e    = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low[i])
                p = p | 6'(i);
        end
        for (int i = 0; i <= WORD_W; i++)
        begin
            if (endb[i])
                e = e | 6'(i);
        end
        n = e - p;
        case (n[5:3])
            3'd1:    rep = 25'h000_0001;
            3'd2:    rep = 25'h000_0101;
            3'd3:    rep = 25'h001_0101;
            3'd4:    rep = 25'h101_0101;
            default: rep = '0;
        endcase
        res.mask = m;
        res.pos  = p[4:0];
        res.qn   = rep << n[2:0];
        res.rm1  = 7'((8'd1 << n[2:0]) - 8'd1);
        return res;
    endfunction

    logic [1:0]                 fmt_reg;
    logic                       visual_reg;
    chan_place_t [NUM_CHAN-1:0] place_reg;
    chan_place_t                wr_place;

    assign cfg_ready = 1'b1;
    assign wr_place  = calc_place(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg             <= FMT_YUV;
            visual_reg          <= 1'b0;
            place_reg[CH_RED]   <= calc_place(RED_MASK_RST);
            place_reg[CH_GREEN] <= calc_place(GREEN_MASK_RST);
            place_reg[CH_BLUE]  <= calc_place(BLUE_MASK_RST);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_FORMAT:     fmt_reg             <= cfg_data[1:0];
                REG_VISUAL_PRESENT: visual_reg          <= cfg_data[0];
                REG_RED_MASK:       place_reg[CH_RED]   <= wr_place;
                REG_GREEN_MASK:     place_reg[CH_GREEN] <= wr_place;
                REG_BLUE_MASK:      place_reg[CH_BLUE]  <= wr_place;
                default:            ;
            endcase
        end
    end

    assign cfg.src_format     = fmt_reg;
    assign cfg.visual_present = visual_reg;
    assign cfg.place          = place_reg;

endmodule

`default_nettype wire

@@ rtl/yrv_csc.sv @@
// Colour conversion pipeline: input register, BT.601 products, sum/clamp/select.
// Depends on yrv_pkg.
`default_nettype none

module yrv_csc
    import yrv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] src_format,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_a,
    input  logic [7:0] in_b,
    input  logic [7:0] in_c,
    output logic       out_valid,
    input  logic       out_ready,
    output rgb_t       out_pix
);

    localparam int COEF_W = 18;
    localparam int PROD_W = 26;

    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd91881;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22554;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46802;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116130;

    function automatic logic [7:0] sat_byte(input logic signed [12:0] v);
        logic [7:0] res;
        if (v < 13'sd0)
            res = 8'd0;
        else if (v > 13'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

    // stage 1: input register
    logic              s1_valid_reg;
    logic [7:0]        a1_reg, b1_reg, c1_reg;
    // stage 2: products
    logic              s2_valid_reg;
    logic [7:0]        a2_reg, b2_reg, c2_reg;
    logic signed [PROD_W-1:0] p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [PROD_W-1:0] p_rv_next, p_gu_next, p_gv_next, p_bu_next;
    // stage 3: channel bytes
    logic              s3_valid_reg;
    rgb_t              pix3_reg;
    rgb_t              pix3_next;

    logic rdy1, rdy2, rdy3;
    logic signed [7:0] u_s, v_s;
    logic signed [9:0]  r_off, b_off;
    logic signed [PROD_W:0] g_sum;
    logic signed [10:0] g_off;
    logic signed [12:0] y_s, r_val, g_val, b_val;

    assign rdy3     = !s3_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    // chroma minus 128 is the byte with its top bit flipped, read as signed
    assign u_s = signed'({~b1_reg[7], b1_reg[6:0]});
    assign v_s = signed'({~c1_reg[7], c1_reg[6:0]});

    assign p_rv_next = PROD_W'(v_s) * PROD_W'(COEF_RV);
    assign p_gu_next = PROD_W'(u_s) * PROD_W'(COEF_GU);
    assign p_gv_next = PROD_W'(v_s) * PROD_W'(COEF_GV);
    assign p_bu_next = PROD_W'(u_s) * PROD_W'(COEF_BU);

    // taking the upper bits is a floor division by 2^16
    assign g_sum = (PROD_W+1)'(p_gu_reg) + (PROD_W+1)'(p_gv_reg);
    assign r_off = p_rv_reg[PROD_W-1:16];
    assign b_off = p_bu_reg[PROD_W-1:16];
    assign g_off = g_sum[PROD_W:16];
    assign y_s   = signed'({5'd0, a2_reg});
    assign r_val = y_s + 13'(r_off);
    assign g_val = y_s - 13'(g_off);
    assign b_val = y_s + 13'(b_off);

    always_comb
    begin
        pix3_next = '0;
        case (src_format)
            FMT_YUV:
            begin
                pix3_next.r = sat_byte(r_val);
                pix3_next.g = sat_byte(g_val);
                pix3_next.b = sat_byte(b_val);
            end
            FMT_RGB24:
            begin
                pix3_next.r = a2_reg;
                pix3_next.g = b2_reg;
                pix3_next.b = c2_reg;
            end
            FMT_BGR24:
            begin
                pix3_next.r = c2_reg;
                pix3_next.g = b2_reg;
                pix3_next.b = a2_reg;
            end
            default:
                pix3_next.bad = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            a1_reg <= in_a;
            b1_reg <= in_b;
            c1_reg <= in_c;
        end
        if (rdy2 && s1_valid_reg)
        begin
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            p_rv_reg <= p_rv_next;
            p_gu_reg <= p_gu_next;
            p_gv_reg <= p_gv_next;
            p_bu_reg <= p_bu_next;
        end
        if (rdy3 && s2_valid_reg)
            pix3_reg <= pix3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_pix   = pix3_reg;

endmodule

`default_nettype wire

@@ rtl/yrv_pack.sv @@
// Pixel packing pipeline: channel scale products, then round, place, merge.
// Depends on yrv_pkg; holds the output register.
`default_nettype none

module yrv_pack
    import yrv_pkg::*;
#(
    parameter int PIXEL_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgb_t              in_pix,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word
);

    localparam logic [63:0] LIMIT_64 =
        (PIXEL_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << PIXEL_BITS) - 64'd1);
    localparam logic [WORD_W-1:0] LIMIT_MASK = LIMIT_64[WORD_W-1:0];

    logic                      s4_valid_reg;
    rgb_t                      pix4_reg;
    logic [NUM_CHAN-1:0][WORD_W-1:0] hi4_reg;
    logic [NUM_CHAN-1:0][14:0]       lo4_reg;
    logic [NUM_CHAN-1:0][WORD_W-1:0] hi4_next;
    logic [NUM_CHAN-1:0][14:0]       lo4_next;

    logic                      s5_valid_reg;
    logic [WORD_W-1:0]         word_reg;
    logic [WORD_W-1:0]         word_next;

    logic [NUM_CHAN-1:0][7:0]        chan_in;
    logic [NUM_CHAN-1:0][WORD_W-1:0] placed;
    logic rdy4, rdy5;

    assign rdy5     = !s5_valid_reg || out_ready;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign in_ready = rdy4;

    assign chan_in[CH_RED]   = in_pix.r;
    assign chan_in[CH_GREEN] = in_pix.g;
    assign chan_in[CH_BLUE]  = in_pix.b;

    for (genvar k = 0; k < NUM_CHAN; k++)
    begin : g_chan
        logic [22:0]       t;
        logic [6:0]        q0;
        logic [15:0]       rem;
        logic [6:0]        q;
        logic [WORD_W-1:0] scaled;

        // c*(2^n-1)+127 split into whole multiples of 255 and a small rest
        assign hi4_next[k] = WORD_W'(40'(chan_in[k]) * 40'(cfg.place[k].qn));
        assign lo4_next[k] = 15'(chan_in[k]) * 15'(cfg.place[k].rm1) + 15'd127;

        // rest / 255: multiply by 257/65536, then one correction step
        assign t      = {lo4_reg[k], 8'd0} + 23'(lo4_reg[k]);
        assign q0     = t[22:16];
        assign rem    = 16'(lo4_reg[k]) - {1'b0, q0, 8'd0} + 16'(q0);
        assign q      = (rem >= 16'd255) ? q0 + 7'd1 : q0;
        assign scaled = hi4_reg[k] + WORD_W'(q);
        assign placed[k] = (scaled << cfg.place[k].pos) & cfg.place[k].mask;
    end

    always_comb
    begin
        if (pix4_reg.bad)
            word_next = '0;
        else if (cfg.visual_present)
            word_next = placed[CH_RED] | placed[CH_GREEN] | placed[CH_BLUE];
        else
            word_next = {8'd0, pix4_reg.r, pix4_reg.g, pix4_reg.b};
        word_next = word_next & LIMIT_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                s4_valid_reg <= in_valid;
            if (rdy5)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            pix4_reg <= in_pix;
            hi4_reg  <= hi4_next;
            lo4_reg  <= lo4_next;
        end
        if (rdy5 && s4_valid_reg)
            word_reg <= word_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire
